### src/vec3_pkg.sv
`default_nettype none
package vec3_pkg;

  typedef enum logic [2:0] {
    KIND_ADD       = 3'd0,
    KIND_SUB       = 3'd1,
    KIND_DOT       = 3'd2,
    KIND_NORM      = 3'd3,
    KIND_NORMALIZE = 3'd4,
    KIND_SCALE     = 3'd5,
    KIND_CROSS     = 3'd6,
    KIND_ROTATE    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned SAT_W      = 72;

  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t s;
    logic  ovf;
  } res_t;

  typedef struct packed {
    kind_e kind;
    res_t  res;
  } dly_t;

  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[SAT_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/vec3_delay.sv
`default_nettype none
module vec3_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
  end

  for (genvar s = 1; s < DEPTH; s++) begin : g_tap
    always_ff @(posedge clk_i) begin
      tap_q[s] <= tap_q[s-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule
`default_nettype wire

### src/vec3_lane.sv
`default_nettype none
module vec3_lane import vec3_pkg::*; (
  input  wire logic  clk_i,
  input  wire kind_e kind_i,
  input  wire word_t ai_i,
  input  wire word_t aj_i,
  input  wire word_t ak_i,
  input  wire word_t bi_i,
  input  wire word_t bj_i,
  input  wire word_t bk_i,
  input  wire word_t w_i,
  input  wire word_t f_i,
  output prod_t      p0_o,
  output prod_t      p1_o,
  output prod_t      p2_o,
  output sat_t       as_o
);

  word_t x0, y0, x1, y1, x2, y2;
  logic signed [32:0] sum;
  prod_t p0_q, p1_q, p2_q;
  sat_t  as_q;

  always_comb begin
    x0 = '0; y0 = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0;
    case (kind_i)
      KIND_DOT: begin
        x0 = ai_i; y0 = bi_i;
      end
      KIND_NORM, KIND_NORMALIZE: begin
        x0 = ai_i; y0 = ai_i;
      end
      KIND_SCALE: begin
        x0 = ai_i; y0 = f_i;
      end
      KIND_CROSS: begin
        x0 = aj_i; y0 = bk_i;
        x1 = ak_i; y1 = bj_i;
      end
      KIND_ROTATE: begin
        x0 = bi_i; y0 = bi_i;
        x1 = bi_i; y1 = bj_i;
        x2 = w_i;  y2 = bi_i;
      end
      default: begin
      end
    endcase
    sum = (kind_i == KIND_SUB) ? 33'(ai_i) - 33'(bi_i) : 33'(ai_i) + 33'(bi_i);
  end

  always_ff @(posedge clk_i) begin
    p0_q <= 64'(x0) * 64'(y0);
    p1_q <= 64'(x1) * 64'(y1);
    p2_q <= 64'(x2) * 64'(y2);
    as_q <= sat32(SAT_W'(sum));
  end

  assign p0_o = p0_q;
  assign p1_o = p1_q;
  assign p2_o = p2_q;
  assign as_o = as_q;

endmodule
`default_nettype wire

### src/vec3_isqrt.sv
`default_nettype none
module vec3_isqrt import vec3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [63:0] x_i,
  output logic      [31:0] root_o
);

  logic [63:0] x_q [1:SQRT_STEPS];
  logic [63:0] r_q [1:SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (2 * (SQRT_STEPS - 1 - s));
    logic [63:0] cx, cr, t;
    if (s == 0) begin : g_first
      assign cx = x_i;
      assign cr = '0;
    end else begin : g_next
      assign cx = x_q[s];
      assign cr = r_q[s];
    end
    assign t = cr + Bit;
    always_ff @(posedge clk_i) begin
      if (cx >= t) begin
        x_q[s+1] <= cx - t;
        r_q[s+1] <= (cr >> 1) + Bit;
      end else begin
        x_q[s+1] <= cx;
        r_q[s+1] <= cr >> 1;
      end
    end
  end

  assign root_o = r_q[SQRT_STEPS][31:0];

endmodule
`default_nettype wire

### src/vec3_div.sv
`default_nettype none
module vec3_div import vec3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire word_t       a_i,
  input  wire logic [31:0] n_i,
  output logic      [31:0] q_o,
  output logic             ovf_o,
  output logic             neg_o
);

  logic [31:0] mag;
  logic [63:0] num;
  logic [63:0] rem_q [0:DIV_STEPS];
  logic [31:0] dvs_q [0:DIV_STEPS];
  logic [31:0] quo_q [0:DIV_STEPS];
  logic        ovf_q [0:DIV_STEPS];
  logic        neg_q [0:DIV_STEPS];

  assign mag = a_i[31] ? 32'(-a_i) : 32'(a_i);
  assign num = 64'(mag) << FRAC_BITS;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num;
    dvs_q[0] <= n_i;
    quo_q[0] <= '0;
    ovf_q[0] <= num >= {n_i, 32'd0};
    neg_q[0] <= a_i[31];
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int unsigned Sh = DIV_STEPS - 1 - s;
    logic [63:0] trial;
    assign trial = 64'(dvs_q[s]) << Sh;
    always_ff @(posedge clk_i) begin
      if (rem_q[s] >= trial) begin
        rem_q[s+1] <= rem_q[s] - trial;
        quo_q[s+1] <= {quo_q[s][30:0], 1'b1};
      end else begin
        rem_q[s+1] <= rem_q[s];
        quo_q[s+1] <= {quo_q[s][30:0], 1'b0};
      end
      dvs_q[s+1] <= dvs_q[s];
      ovf_q[s+1] <= ovf_q[s];
      neg_q[s+1] <= neg_q[s];
    end
  end

  assign q_o   = quo_q[DIV_STEPS];
  assign ovf_o = ovf_q[DIV_STEPS];
  assign neg_o = neg_q[DIV_STEPS];

endmodule
`default_nettype wire

### src/vector3_alu_core.sv
// Vector ALU for signed fixed-point 3-vectors: add, sub, dot, norm, normalize,
// scale, cross and quaternion rotate. A new item is taken on every clock and
// busy_o never rises. Each result strobes valid_o for one cycle, in order; the
// receiver cannot stall. Every kind passes through the same pipeline, whose
// depth is set by the 32-step pipelined square root followed by the 33-stage
// pipelined divider used by normalize.
`default_nettype none
module vector3_alu_core import vec3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  kind_i,
  input  wire word_t       a_x_i,
  input  wire word_t       a_y_i,
  input  wire word_t       a_z_i,
  input  wire word_t       b_x_i,
  input  wire word_t       b_y_i,
  input  wire word_t       b_z_i,
  input  wire word_t       q_w_i,
  input  wire word_t       factor_i,
  output logic             valid_o,
  output word_t            res_x_o,
  output word_t            res_y_o,
  output word_t            res_z_o,
  output word_t            res_scalar_o,
  output logic [1:0]       status_o
);

  localparam int unsigned Last    = 2 + SQRT_STEPS + 1 + DIV_STEPS;
  localparam int unsigned DirDly  = Last - 4;
  localparam logic signed [SAT_W-1:0] One = SAT_W'(1) <<< FRAC_BITS;

  logic [Last:0] vld_q;
  logic          out_vld_q;

  kind_e kind0_q, kind1_q, kind2_q, kind3_q, kind4_q;
  word_t a0_q [3];
  word_t b0_q [3];
  word_t w0_q, f0_q;
  word_t a1_q [3];
  word_t a2_q [3];

  prod_t p0_w [3];
  prod_t p1_w [3];
  prod_t p2_w [3];
  sat_t  as_w [3];

  res_t  res2_d, res2_q, res3_q, res4_d, res4_q;
  word_t m2_d [9];
  word_t m2_q [9];
  logic  msat2_d, msat2_q, msat3_q;
  logic [63:0] sq2_q;
  prod_t mp3_q [3][3];

  logic [31:0] n34;
  logic [95:0] a34;
  logic [31:0] n67;
  dly_t        dly67;
  logic [31:0] q67 [3];
  logic        dovf67 [3];
  logic        neg67 [3];

  res_t    out_d;
  status_e st_d;
  res_t    out_q;
  status_e st_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[Last-1:0], start_i};
      out_vld_q <= vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      kind0_q <= kind_e'(kind_i);
      a0_q[0] <= a_x_i; a0_q[1] <= a_y_i; a0_q[2] <= a_z_i;
      b0_q[0] <= b_x_i; b0_q[1] <= b_y_i; b0_q[2] <= b_z_i;
      w0_q    <= q_w_i;
      f0_q    <= factor_i;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vec3_lane u_lane (
      .clk_i  (clk_i),
      .kind_i (kind0_q),
      .ai_i   (a0_q[i]),
      .aj_i   (a0_q[(i+1)%3]),
      .ak_i   (a0_q[(i+2)%3]),
      .bi_i   (b0_q[i]),
      .bj_i   (b0_q[(i+1)%3]),
      .bk_i   (b0_q[(i+2)%3]),
      .w_i    (w0_q),
      .f_i    (f0_q),
      .p0_o   (p0_w[i]),
      .p1_o   (p1_w[i]),
      .p2_o   (p2_w[i]),
      .as_o   (as_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    kind1_q <= kind0_q;
    a1_q    <= a0_q;
  end

  // merge of lane products and add/sub sums
  always_comb begin
    logic signed [65:0] dsum;
    logic signed [64:0] cd;
    logic signed [SAT_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [SAT_W-1:0] mr [9];
    sat_t sv [3];
    sat_t ms;
    res2_d  = '0;
    msat2_d = 1'b0;
    dsum    = '0;
    cd      = '0;
    for (int i = 0; i < 3; i++) sv[i] = '0;
    case (kind1_q)
      KIND_ADD, KIND_SUB: begin
        for (int i = 0; i < 3; i++) sv[i] = as_w[i];
      end
      KIND_SCALE: begin
        for (int i = 0; i < 3; i++) sv[i] = sat32(SAT_W'(p0_w[i] >>> FRAC_BITS));
      end
      KIND_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          cd = 65'(p0_w[i]) - 65'(p1_w[i]);
          sv[i] = sat32(SAT_W'(cd >>> FRAC_BITS));
        end
      end
      default: begin
      end
    endcase
    res2_d.x   = sv[0].val;
    res2_d.y   = sv[1].val;
    res2_d.z   = sv[2].val;
    res2_d.ovf = sv[0].ovf | sv[1].ovf | sv[2].ovf;
    if (kind1_q == KIND_DOT) begin
      dsum = 66'(p0_w[0]) + 66'(p0_w[1]) + 66'(p0_w[2]);
      ms   = sat32(SAT_W'(dsum >>> FRAC_BITS));
      res2_d.s   = ms.val;
      res2_d.ovf = ms.ovf;
    end
    xx = SAT_W'(p0_w[0] >>> FRAC_BITS);
    yy = SAT_W'(p0_w[1] >>> FRAC_BITS);
    zz = SAT_W'(p0_w[2] >>> FRAC_BITS);
    xy = SAT_W'(p1_w[0] >>> FRAC_BITS);
    yz = SAT_W'(p1_w[1] >>> FRAC_BITS);
    xz = SAT_W'(p1_w[2] >>> FRAC_BITS);
    wx = SAT_W'(p2_w[0] >>> FRAC_BITS);
    wy = SAT_W'(p2_w[1] >>> FRAC_BITS);
    wz = SAT_W'(p2_w[2] >>> FRAC_BITS);
    mr[0] = One - (yy <<< 1) - (zz <<< 1);
    mr[1] = (xy <<< 1) + (wz <<< 1);
    mr[2] = (xz <<< 1) - (wy <<< 1);
    mr[3] = (xy <<< 1) - (wz <<< 1);
    mr[4] = One - (xx <<< 1) - (zz <<< 1);
    mr[5] = (yz <<< 1) + (wx <<< 1);
    mr[6] = (xz <<< 1) + (wy <<< 1);
    mr[7] = (yz <<< 1) - (wx <<< 1);
    mr[8] = One - (xx <<< 1) - (yy <<< 1);
    for (int k = 0; k < 9; k++) begin
      ms = sat32(mr[k]);
      m2_d[k] = ms.val;
      msat2_d = msat2_d | (ms.ovf & (kind1_q == KIND_ROTATE));
    end
  end

  always_ff @(posedge clk_i) begin
    res2_q  <= res2_d;
    m2_q    <= m2_d;
    msat2_q <= msat2_d;
    sq2_q   <= 64'(p0_w[0]) + 64'(p0_w[1]) + 64'(p0_w[2]);
    kind2_q <= kind1_q;
    a2_q    <= a1_q;
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        mp3_q[i][j] <= 64'(m2_q[3*i+j]) * 64'(a2_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res3_q  <= res2_q;
    msat3_q <= msat2_q;
    kind3_q <= kind2_q;
  end

  always_comb begin
    logic signed [65:0] rs;
    sat_t rv [3];
    res4_d = res3_q;
    for (int i = 0; i < 3; i++) begin
      rs = 66'(mp3_q[i][0]) + 66'(mp3_q[i][1]) + 66'(mp3_q[i][2]);
      rv[i] = sat32(SAT_W'(rs >>> FRAC_BITS));
    end
    if (kind3_q == KIND_ROTATE) begin
      res4_d.x   = rv[0].val;
      res4_d.y   = rv[1].val;
      res4_d.z   = rv[2].val;
      res4_d.s   = '0;
      res4_d.ovf = msat3_q | rv[0].ovf | rv[1].ovf | rv[2].ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    res4_q  <= res4_d;
    kind4_q <= kind3_q;
  end

  vec3_isqrt u_isqrt (
    .clk_i  (clk_i),
    .x_i    (sq2_q),
    .root_o (n34)
  );

  vec3_delay #(.WIDTH(96), .DEPTH(SQRT_STEPS)) u_a_dly (
    .clk_i (clk_i),
    .d_i   ({a2_q[2], a2_q[1], a2_q[0]}),
    .q_o   (a34)
  );

  vec3_delay #(.WIDTH(32), .DEPTH(DIV_STEPS + 1)) u_n_dly (
    .clk_i (clk_i),
    .d_i   (n34),
    .q_o   (n67)
  );

  vec3_delay #(.WIDTH($bits(dly_t)), .DEPTH(DirDly)) u_res_dly (
    .clk_i (clk_i),
    .d_i   ({kind4_q, res4_q}),
    .q_o   (dly67)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    vec3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .a_i   (a34[32*i +: 32]),
      .n_i   (n34),
      .q_o   (q67[i]),
      .ovf_o (dovf67[i]),
      .neg_o (neg67[i])
    );
  end

  always_comb begin
    logic  ov;
    word_t nv [3];
    logic  nov [3];
    out_d = dly67.res;
    for (int i = 0; i < 3; i++) begin
      ov = dovf67[i] | (neg67[i] ? (q67[i] > 32'h8000_0000) : q67[i][31]);
      nov[i] = ov;
      if (ov) begin
        nv[i] = neg67[i] ? WORD_MIN : WORD_MAX;
      end else begin
        nv[i] = neg67[i] ? -$signed(q67[i]) : $signed(q67[i]);
      end
    end
    case (dly67.kind)
      KIND_NORM: begin
        out_d = '0;
        out_d.s   = n67[31] ? WORD_MAX : $signed(n67);
        out_d.ovf = n67[31];
      end
      KIND_NORMALIZE: begin
        out_d = '0;
        if (n67 != '0) begin
          out_d.x   = nv[0];
          out_d.y   = nv[1];
          out_d.z   = nv[2];
          out_d.ovf = nov[0] | nov[1] | nov[2];
        end
      end
      default: begin
      end
    endcase
    if (dly67.kind == KIND_NORMALIZE && n67 == '0) begin
      st_d = ST_ZERO;
    end else begin
      st_d = out_d.ovf ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    st_q  <= st_d;
  end

  assign valid_o      = out_vld_q;
  assign res_x_o      = out_q.x;
  assign res_y_o      = out_q.y;
  assign res_z_o      = out_q.z;
  assign res_scalar_o = out_q.s;
  assign status_o     = st_q;

endmodule
`default_nettype wire
